>>> rtl/core/positional_insert_delete_array_assert.svh
// assertion macros for the positional insert/delete array
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define PIDA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pida_pkg.sv
// types and constants shared by the positional insert/delete array
package pida_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 6;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int FILL_W = 5;
   // slot and count width inside the cell chain, enough for up to 64 entries
   localparam int CTL_W  = 7;

   localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SHOW      = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_INS  = 2'd1;
   localparam logic [1:0] CELL_DEL  = 2'd2;
   localparam logic [1:0] CELL_ROT  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] element;
      logic [STAT_W-1:0]        status;
      logic [FILL_W-1:0]        fill_count;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]               op;
      logic [CTL_W-1:0]         slot;
      logic [CTL_W-1:0]         count;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] head;
   } cell_ctl_type;

endpackage

>>> rtl/core/pida_if.sv
// valid/ready channel interfaces for commands and result items
interface pida_req_if import pida_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pida_rsp_if import pida_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/positional_insert_delete_array.sv
// Positional insert/delete array: ordered store of signed words in a chain of cells.
//
// req_ch carries one command per item (insert at position, insert first, insert
// last, delete at position, display). rsp_ch returns result items with the stored
// word (display only), a status, the fill count after the command and a last flag.
// Both channels move an item when valid and ready are high at a rising clock edge.
//
// Insert and delete shift the cells from the target position on by one place in
// the cycle the command is taken; its single result item is visible the next
// cycle. A command is taken every cycle while rsp_ch keeps up, so insert/delete
// run at one item per cycle. Display of n entries rotates the cell chain once per
// result item loaded and gives n result items, after which the chain is back in
// order; req_ch is held off until the last of those items has been loaded.
//
// A stalled rsp_ch holds its item in the output register; req_ch and the display
// rotation wait until it is free. Synchronous reset empties the array (count zero)
// and drops any pending result; the cell contents are not cleared.
module positional_insert_delete_array import pida_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   pida_req_if.sink   req_ch,
   pida_rsp_if.source rsp_ch
);

   `include "positional_insert_delete_array_assert.svh"

   localparam int            CW    = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic          S_IDLE = 1'b0;
   localparam logic          S_SHOW = 1'b1;

   logic                     state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     out_free;
   logic                     req_accept;
   logic                     show_load;
   logic [CTL_W-1:0]         cnt_x;
   logic [CTL_W-1:0]         eff_pos;
   cell_ctl_type             ctl;
   logic signed [WORD_W-1:0] cell_data [CAPACITY];

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign show_load    = (state_ff == S_SHOW) && out_free;
   assign cnt_x        = CTL_W'(count_ff);

   always_comb begin
      case (req_ch.data.command)
         CMD_INS_FIRST: eff_pos = CTL_W'(1);
         CMD_INS_LAST:  eff_pos = cnt_x + CTL_W'(1);
         default:       eff_pos = CTL_W'(req_ch.data.position);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      ctl.op       = CELL_HOLD;
      ctl.slot     = eff_pos - CTL_W'(1);
      ctl.count    = cnt_x;
      ctl.value    = req_ch.data.value;
      ctl.head     = cell_data[0];

      if (req_accept) begin
         rsp_data_in.element = '0;
         rsp_data_in.status  = ST_OK;
         rsp_data_in.last    = 1'b1;
         rsp_valid_in        = 1'b1;
         case (req_ch.data.command)
            CMD_INS_AT, CMD_INS_FIRST, CMD_INS_LAST: begin
               if (count_ff == CAP_C) begin
                  rsp_data_in.status = ST_FULL;
               end else if (eff_pos == '0 || eff_pos > cnt_x + CTL_W'(1)) begin
                  rsp_data_in.status = ST_BADPOS;
               end else begin
                  ctl.op   = CELL_INS;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_DEL_AT: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else if (eff_pos == '0 || eff_pos > cnt_x) begin
                  rsp_data_in.status = ST_BADPOS;
               end else begin
                  ctl.op   = CELL_DEL;
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_SHOW: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  // words leave from the head while the chain rotates
                  rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                  state_in     = S_SHOW;
                  idx_in       = '0;
               end
            end
            default: begin
               rsp_data_in.status = ST_OK;
            end
         endcase
         rsp_data_in.fill_count = FILL_W'(count_in);
      end else if (show_load) begin
         ctl.op                 = CELL_ROT;
         rsp_valid_in           = 1'b1;
         rsp_data_in.element    = cell_data[0];
         rsp_data_in.status     = ST_OK;
         rsp_data_in.fill_count = FILL_W'(count_ff);
         rsp_data_in.last       = (idx_ff == count_ff - CW'(1));
         idx_in                 = idx_ff + CW'(1);
         if (idx_ff == count_ff - CW'(1)) begin
            state_in = S_IDLE;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_d;
      logic signed [WORD_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      pida_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   `PIDA_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CAP_C, "fill count above capacity")
   `PIDA_ASSERT_NOW(a_no_req_in_show, state_ff == S_SHOW, !req_accept, "item taken during display")
   `PIDA_ASSERT_NEXT(a_count_held, state_ff == S_SHOW, count_ff == $past(count_ff), "count moved during display")
   `PIDA_ASSERT_NEXT(a_show_ends, show_load && rsp_data_in.last, state_ff == S_IDLE && rsp_valid_ff, "display did not finish on last word")
   `PIDA_ASSERT_NOW(a_show_idx, state_ff == S_SHOW, idx_ff < count_ff, "display index past fill count")

endmodule

>>> rtl/core/pida_cell.sv
// one storage cell of the entry chain
module pida_cell import pida_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [WORD_W-1:0] left_data,
   input  logic signed [WORD_W-1:0] right_data,
   output logic signed [WORD_W-1:0] data
);

   localparam logic [CTL_W-1:0] IDX_L = CTL_W'(IDX);
   localparam logic [CTL_W-1:0] IDX_N = CTL_W'(IDX + 1);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INS: begin
            if (IDX_L == ctl.slot) begin
               data_in = ctl.value;
            end else if (IDX_L > ctl.slot) begin
               data_in = left_data;
            end
         end
         CELL_DEL: begin
            if (IDX_L >= ctl.slot) begin
               data_in = right_data;
            end
         end
         CELL_ROT: begin
            // last stored cell wraps round to the head
            if (IDX_N < ctl.count) begin
               data_in = right_data;
            end else if (IDX_N == ctl.count) begin
               data_in = ctl.head;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
